// ----- design/ccdp_pkg.sv -----
`timescale 1ns / 1ps

package ccdp_pkg;

	// bus operation codes
	typedef enum logic [2:0] {
		OP_READ_AB  = 3'd0,
		OP_WRITE_AB = 3'd1,
		OP_READ_C   = 3'd2,
		OP_BSR_C    = 3'd3,
		OP_WRITE_C  = 3'd4,
		OP_SET_MODE = 3'd5
	} op_t;

	// timing mode register codes
	localparam logic [1:0] TM_SWAP = 2'd0;
	localparam logic [1:0] TM_DUAL = 2'd1;

	// mode byte bit positions
	localparam int MODE_A_IN  = 4;
	localparam int MODE_CH_IN = 3;
	localparam int MODE_B_IN  = 1;
	localparam int MODE_CL_IN = 0;

	// bit set/reset command: nibble select bit
	localparam int BSR_HIGH_BIT = 3;

	// one result of an access
	typedef struct packed {
		logic [7:0] rdata;
		logic       swap_cpu;
		logic       start_dual;
		logic       break_off;
	} res_t;

endpackage

// ----- design/ccdp_core.sv -----
`timescale 1ns / 1ps

module ccdp_core import ccdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [2:0] operation,
	input  logic       side,
	input  logic       port,
	input  logic [7:0] wdata,
	input  logic [1:0] timing_mode,
	output res_t       res
);

	// a/b index is {side, port}
	logic [3:0]       ab_is_input_q, ab_is_input_d;
	logic [3:0]       ab_full_q, ab_full_d;
	logic [3:0][7:0]  ab_latch_q, ab_latch_d;
	logic [1:0]       ch_is_input_q, ch_is_input_d;
	logic [1:0]       cl_is_input_q, cl_is_input_d;
	logic [1:0][3:0]  ch_nibble_q, ch_nibble_d;
	logic [1:0][3:0]  cl_nibble_q, cl_nibble_d;
	logic [1:0]       c_read_phase_q, c_read_phase_d;

	logic       other;
	logic [1:0] own;
	logic [1:0] peer;
	logic [1:0] bit_sel;
	logic       main_dual;
	logic [3:0] hi;
	logic [3:0] lo;

	assign other     = ~side;
	assign own       = {side, port};
	assign peer      = {~side, ~port};
	assign bit_sel   = wdata[2:1];
	assign main_dual = (timing_mode == TM_DUAL) && !side;
	assign hi = ch_is_input_q[side] ? cl_nibble_q[other] : ch_nibble_q[side];
	assign lo = cl_is_input_q[side] ? ch_nibble_q[other] : cl_nibble_q[side];

	always_comb begin
		res            = '0;
		ab_is_input_d  = ab_is_input_q;
		ab_full_d      = ab_full_q;
		ab_latch_d     = ab_latch_q;
		ch_is_input_d  = ch_is_input_q;
		cl_is_input_d  = cl_is_input_q;
		ch_nibble_d    = ch_nibble_q;
		cl_nibble_d    = cl_nibble_q;
		c_read_phase_d = c_read_phase_q;
		case (operation)
			OP_READ_AB: begin
				if (!ab_is_input_q[own]) begin
					res.rdata = ab_latch_q[own];
				end else begin
					if (ab_full_q[peer]) begin
						ab_full_d[peer] = 1'b0;
					end else if (main_dual) begin
						res.start_dual = 1'b1;
						res.break_off  = 1'b1;
					end
					res.rdata = ab_latch_q[peer];
				end
			end
			OP_WRITE_AB: begin
				if (!ab_full_q[own]) begin
					ab_full_d[own] = 1'b1;
				end else if (main_dual) begin
					res.start_dual = 1'b1;
					res.break_off  = 1'b1;
				end
				ab_latch_d[own] = wdata;
			end
			OP_READ_C: begin
				res.rdata = {hi, lo};
				c_read_phase_d[side] = ~c_read_phase_q[side];
				// phase goes to zero: flagged read
				if (c_read_phase_q[side]) begin
					if (timing_mode == TM_SWAP) begin
						res.swap_cpu  = 1'b1;
						res.break_off = 1'b1;
					end else if (main_dual) begin
						res.start_dual = 1'b1;
						res.break_off  = 1'b1;
					end
				end
			end
			OP_BSR_C: begin
				if (wdata[BSR_HIGH_BIT]) begin
					ch_nibble_d[side][bit_sel] = wdata[0];
				end else begin
					cl_nibble_d[side][bit_sel] = wdata[0];
				end
				if (main_dual) begin
					res.start_dual = 1'b1;
					res.break_off  = 1'b1;
				end
			end
			OP_WRITE_C: begin
				ch_nibble_d[side] = wdata[7:4];
				cl_nibble_d[side] = wdata[3:0];
				if (main_dual) begin
					res.start_dual = 1'b1;
					res.break_off  = 1'b1;
				end
			end
			OP_SET_MODE: begin
				ab_is_input_d[{side, 1'b0}] = wdata[MODE_A_IN];
				ab_is_input_d[{side, 1'b1}] = wdata[MODE_B_IN];
				ab_latch_d[{side, 1'b0}]    = '0;
				ab_latch_d[{side, 1'b1}]    = '0;
				ab_full_d[{side, 1'b0}]     = 1'b0;
				ab_full_d[{side, 1'b1}]     = 1'b0;
				ch_is_input_d[side]         = wdata[MODE_CH_IN];
				cl_is_input_d[side]         = wdata[MODE_CL_IN];
				ch_nibble_d[side]           = '0;
				cl_nibble_d[side]           = '0;
				c_read_phase_d[side]        = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ab_is_input_q  <= 4'b0101;
			ab_full_q      <= '0;
			ab_latch_q     <= '0;
			ch_is_input_q  <= '0;
			cl_is_input_q  <= 2'b11;
			ch_nibble_q    <= '0;
			cl_nibble_q    <= '0;
			c_read_phase_q <= 2'b11;
		end else if (accept) begin
			ab_is_input_q  <= ab_is_input_d;
			ab_full_q      <= ab_full_d;
			ab_latch_q     <= ab_latch_d;
			ch_is_input_q  <= ch_is_input_d;
			cl_is_input_q  <= cl_is_input_d;
			ch_nibble_q    <= ch_nibble_d;
			cl_nibble_q    <= cl_nibble_d;
			c_read_phase_q <= c_read_phase_d;
		end
	end

endmodule

// ----- design/cross_coupled_dual_ppi.sv -----
`timescale 1ns / 1ps
// a result is valid the cycle after its request is accepted
// throughput: one request per cycle; the port state is updated at the accepting
//   edge and the result lands in a single output register, which takes a new
//   result whenever it is empty or being drained in the same cycle
// reset: arst_n clears all port state to its power-on values (A input, B output,
//   C-high output, C-low input, latches empty and zero) and timing_mode to zero
module cross_coupled_dual_ppi import ccdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic       side,
	input  logic       port,
	input  logic [7:0] wdata,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] rdata,
	output logic       swap_cpu,
	output logic       start_dual,
	output logic       break_off,
	// timing mode register write
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);

	logic [1:0] timing_mode_q;
	logic       accept;
	res_t       res;
	res_t       res_q;
	logic       out_valid_q;

	// a request is taken when the result register is free or draining now
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// timing mode register, to be written by the user only while idle; the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_mode_q <= TM_SWAP;
		end else if (cfg_we) begin
			timing_mode_q <= cfg_wdata;
		end
	end

	// both port controllers and their crossed wiring
	ccdp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.operation   (operation),
		.side        (side),
		.port        (port),
		.wdata       (wdata),
		.timing_mode (timing_mode_q),
		.res         (res)
	);

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with each accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign rdata      = res_q.rdata;
	assign swap_cpu   = res_q.swap_cpu;
	assign start_dual = res_q.start_dual;
	assign break_off  = res_q.break_off;

endmodule
